// ===== rtl/core/triangle_pixel_raster_zbuffer_defines.svh =====
// Assertion macros shared by the checker of the triangle rasterizer.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef TRIANGLE_PIXEL_RASTER_ZBUFFER_DEFINES_SVH
`define TRIANGLE_PIXEL_RASTER_ZBUFFER_DEFINES_SVH

// Checks that prop holds at every clock edge outside reset.
`define TRPZ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that cond at one edge is followed by nxt at the next edge.
`define TRPZ_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== rtl/core/trpz_pkg.sv =====
// Shared types and constants of the triangle rasterizer with depth buffer.
// Depends on nothing; every file but trpz_ram and the defines header imports it.
`timescale 1ns / 1ps

package trpz_pkg;

	localparam int DEF_SCREEN_WIDTH  = 512;
	localparam int DEF_SCREEN_HEIGHT = 512;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [15:0] DEPTH_CLEAR_RESET = 16'd25600;
	localparam logic [8:0]  MAX_PIXEL_RESET   = 9'd511;
	localparam logic [7:0]  COLOR_MAX         = 8'd255;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_TEST  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_e;

	typedef enum logic [1:0] {
		REG_DEPTH_CLEAR = 2'd0,
		REG_MAX_X       = 2'd1,
		REG_MAX_Y       = 2'd2
	} reg_index_e;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         vertex_slot;
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic [15:0]        vertex_depth;
		logic [7:0]         vertex_red;
		logic [7:0]         vertex_green;
		logic [7:0]         vertex_blue;
		logic [8:0]         pixel_x;
		logic [8:0]         pixel_y;
	} in_t;

	typedef struct packed {
		logic [8:0]  out_x;
		logic [8:0]  out_y;
		logic        pixel_written;
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [15:0] out_depth;
	} out_t;

	typedef struct packed {
		kind_e              kind;
		logic [1:0]         slot;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic [15:0]        vdepth;
		logic [7:0]         vred;
		logic [7:0]         vgreen;
		logic [7:0]         vblue;
		logic [8:0]         px;
		logic [8:0]         py;
		logic               on_screen;
	} cmd_t;

	typedef struct packed {
		logic [15:0] depth_clear;
		logic [8:0]  max_x;
		logic [8:0]  max_y;
	} cfg_t;

endpackage

// ===== rtl/core/trpz_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module trpz_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/trpz_front.sv =====
// Front end: accepts input transactions, drops those without effect and
// marks off-screen pixels before they enter the queue. Depends on trpz_pkg.
`timescale 1ns / 1ps

module trpz_front #(
	parameter int SCREEN_WIDTH  = trpz_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = trpz_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic           in_valid,
	output logic           in_ready,
	input  trpz_pkg::in_t  in_data,
	input  logic           q_full,
	output logic           push,
	output trpz_pkg::cmd_t push_data
);
	import trpz_pkg::*;

	localparam int CW = $clog2(SCREEN_WIDTH) > $clog2(SCREEN_HEIGHT) ?
		$clog2(SCREEN_WIDTH) + 1 : $clog2(SCREEN_HEIGHT) + 1;
	localparam int PW = CW > 9 ? CW : 10;

	logic on_screen;
	logic keep;

	assign on_screen = (PW'(in_data.pixel_x) < PW'(SCREEN_WIDTH)) &&
		(PW'(in_data.pixel_y) < PW'(SCREEN_HEIGHT));

	always_comb begin
		unique case (in_data.kind)
			KIND_LOAD:  keep = (in_data.vertex_slot != 2'd3);
			KIND_TEST:  keep = 1'b1;
			KIND_CLEAR: keep = on_screen;
			default:    keep = 1'b0;
		endcase
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full && keep;

	always_comb begin
		push_data.kind      = kind_e'(in_data.kind);
		push_data.slot      = in_data.vertex_slot;
		push_data.vx        = in_data.vertex_x;
		push_data.vy        = in_data.vertex_y;
		push_data.vdepth    = in_data.vertex_depth;
		push_data.vred      = in_data.vertex_red;
		push_data.vgreen    = in_data.vertex_green;
		push_data.vblue     = in_data.vertex_blue;
		push_data.px        = in_data.pixel_x;
		push_data.py        = in_data.pixel_y;
		push_data.on_screen = on_screen;
	end

endmodule

// ===== rtl/core/trpz_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on trpz_pkg.
`timescale 1ns / 1ps

module trpz_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  trpz_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output trpz_pkg::cmd_t head
);
	import trpz_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign full       = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/trpz_back.sv =====
// Back end: holds the triangle corners, evaluates edge functions, blends
// depth and color, divides by the area and updates the depth buffer.
// Depends on trpz_pkg and drives the ports of one trpz_ram.
`timescale 1ns / 1ps

module trpz_back #(
	parameter int SCREEN_WIDTH  = trpz_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = trpz_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  trpz_pkg::cmd_t head,
	output logic           pop,
	input  trpz_pkg::cfg_t cfg,
	output logic           ram_we,
	output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0] ram_waddr,
	output logic [15:0]    ram_wdata,
	output logic           ram_re,
	output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0] ram_raddr,
	input  logic [15:0]    ram_rdata,
	output logic           out_valid,
	input  logic           out_ready,
	output trpz_pkg::out_t out_data
);
	import trpz_pkg::*;

	localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
	localparam int NUM_W  = 52;
	localparam int REM_W  = 34;
	localparam int NCH    = 4;

	localparam logic [1:0] EDGE_W1   = 2'd0;
	localparam logic [1:0] EDGE_W2   = 2'd1;
	localparam logic [1:0] EDGE_W3   = 2'd2;
	localparam logic [1:0] EDGE_AREA = 2'd3;
	localparam logic [1:0] LAST_K    = 2'd2;
	localparam logic [3:0] LAST_STEP = 4'd15;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EMUL = 7'b0000010,
		ST_ESUB = 7'b0000100,
		ST_MMUL = 7'b0001000,
		ST_MADD = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_e;

	state_e             state_q;
	logic signed [15:0] cx_q [3];
	logic signed [15:0] cy_q [3];
	logic [15:0]        cz_q [3];
	logic [23:0]        cc_q [3];
	logic [8:0]         px_q;
	logic [8:0]         py_q;
	logic               on_q;
	logic [1:0]         edge_q;
	logic [1:0]         k_q;
	logic [3:0]         step_q;
	logic signed [35:0] prod0_q;
	logic signed [35:0] prod1_q;
	logic signed [36:0] w_q [4];
	logic [49:0]        mp_q [NCH];
	logic [NUM_W-1:0]   acc_q [NCH];
	logic [REM_W-1:0]   rem_q [NCH];
	logic [15:0]        lo_q [NCH];
	logic               out_valid_q;
	out_t               out_q;

	logic signed [17:0] ptx, pty, ax, ay, bx, by;
	logic signed [17:0] dx, dy, ex, ey;
	logic signed [35:0] prod0, prod1;
	logic signed [36:0] wdiff;
	logic [33:0]        wsel;
	logic [15:0]        vsel [NCH];
	logic [NUM_W-1:0]   nsum [NCH];
	logic [REM_W:0]     trial [NCH];
	logic               ge [NCH];
	logic               covered;
	logic               written;
	logic               out_free;
	logic [ADDR_W-1:0]  head_addr;
	logic [ADDR_W-1:0]  cur_addr;
	logic [7:0]         sat [3];

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign head_addr = ADDR_W'(head.py) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(head.px);
	assign cur_addr  = ADDR_W'(py_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(px_q);

	always_comb begin
		ptx = $signed({5'b0, px_q, 4'b0});
		pty = $signed({5'b0, py_q, 4'b0});
		unique case (edge_q)
			EDGE_W1: begin
				ax = 18'(cx_q[1]); ay = 18'(cy_q[1]); bx = 18'(cx_q[2]); by = 18'(cy_q[2]);
			end
			EDGE_W2: begin
				ax = 18'(cx_q[2]); ay = 18'(cy_q[2]); bx = 18'(cx_q[0]); by = 18'(cy_q[0]);
			end
			default: begin
				ax = 18'(cx_q[0]); ay = 18'(cy_q[0]); bx = 18'(cx_q[1]); by = 18'(cy_q[1]);
			end
		endcase
		if (edge_q == EDGE_AREA) begin
			ptx = 18'(cx_q[2]);
			pty = 18'(cy_q[2]);
		end
		dx    = ptx - ax;
		dy    = pty - ay;
		ex    = bx - ax;
		ey    = by - ay;
		prod0 = dx * ey;
		prod1 = dy * ex;
		wdiff = 37'(prod0_q) - 37'(prod1_q);
	end

	always_comb begin
		unique case (k_q)
			2'd0: begin
				wsel = w_q[0][33:0];
				vsel[0] = cz_q[0]; vsel[1] = 16'(cc_q[0][23:16]);
				vsel[2] = 16'(cc_q[0][15:8]); vsel[3] = 16'(cc_q[0][7:0]);
			end
			2'd1: begin
				wsel = w_q[1][33:0];
				vsel[0] = cz_q[1]; vsel[1] = 16'(cc_q[1][23:16]);
				vsel[2] = 16'(cc_q[1][15:8]); vsel[3] = 16'(cc_q[1][7:0]);
			end
			default: begin
				wsel = w_q[2][33:0];
				vsel[0] = cz_q[2]; vsel[1] = 16'(cc_q[2][23:16]);
				vsel[2] = 16'(cc_q[2][15:8]); vsel[3] = 16'(cc_q[2][7:0]);
			end
		endcase
		for (int c = 0; c < NCH; c++) begin
			nsum[c]  = acc_q[c] + NUM_W'(mp_q[c]);
			trial[c] = {rem_q[c], lo_q[c][15]};
			ge[c]    = trial[c] >= {1'b0, w_q[3][33:0]};
		end
		for (int c = 0; c < 3; c++) begin
			sat[c] = (lo_q[c + 1] > 16'(COLOR_MAX)) ? COLOR_MAX : lo_q[c + 1][7:0];
		end
	end

	assign covered = on_q && (px_q <= cfg.max_x) && (py_q <= cfg.max_y) &&
		(w_q[3] > 0) && !w_q[0][36] && !w_q[1][36] && !w_q[2][36];
	assign written = covered && (lo_q[0] < ram_rdata);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = lo_q[0];
		ram_re    = 1'b0;
		ram_raddr = head_addr;
		if (pop && head.kind == KIND_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = head_addr;
			ram_wdata = cfg.depth_clear;
		end else if (state_q == ST_DONE && out_free && written) begin
			ram_we = 1'b1;
		end
		if (pop && head.kind == KIND_TEST) begin
			ram_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				px_q <= head.px;
				py_q <= head.py;
				on_q <= head.on_screen;
			end
			ST_EMUL: begin
				prod0_q <= prod0;
				prod1_q <= prod1;
			end
			ST_ESUB: begin
				unique case (edge_q)
					EDGE_W1: w_q[0] <= wdiff;
					EDGE_W2: w_q[1] <= wdiff;
					EDGE_W3: w_q[2] <= wdiff;
					default: w_q[3] <= wdiff;
				endcase
				for (int c = 0; c < NCH; c++) begin
					acc_q[c] <= '0;
				end
			end
			ST_MMUL: begin
				for (int c = 0; c < NCH; c++) begin
					mp_q[c] <= wsel * vsel[c];
				end
			end
			ST_MADD: begin
				for (int c = 0; c < NCH; c++) begin
					acc_q[c] <= nsum[c];
					rem_q[c] <= nsum[c][49:16];
					lo_q[c]  <= nsum[c][15:0];
				end
			end
			ST_DIV: begin
				for (int c = 0; c < NCH; c++) begin
					rem_q[c] <= ge[c] ? REM_W'(trial[c] - {1'b0, w_q[3][33:0]}) :
						trial[c][REM_W-1:0];
					lo_q[c]  <= {lo_q[c][14:0], ge[c]};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.out_x         <= px_q;
					out_q.out_y         <= py_q;
					out_q.pixel_written <= written;
					out_q.out_red       <= covered ? sat[0] : '0;
					out_q.out_green     <= covered ? sat[1] : '0;
					out_q.out_blue      <= covered ? sat[2] : '0;
					out_q.out_depth     <= covered ? lo_q[0] : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			edge_q      <= '0;
			k_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				cx_q[i] <= '0;
				cy_q[i] <= '0;
				cz_q[i] <= '0;
				cc_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.kind == KIND_LOAD) begin
						unique case (head.slot)
							2'd0: begin
								cx_q[0] <= head.vx; cy_q[0] <= head.vy; cz_q[0] <= head.vdepth;
								cc_q[0] <= {head.vred, head.vgreen, head.vblue};
							end
							2'd1: begin
								cx_q[1] <= head.vx; cy_q[1] <= head.vy; cz_q[1] <= head.vdepth;
								cc_q[1] <= {head.vred, head.vgreen, head.vblue};
							end
							2'd2: begin
								cx_q[2] <= head.vx; cy_q[2] <= head.vy; cz_q[2] <= head.vdepth;
								cc_q[2] <= {head.vred, head.vgreen, head.vblue};
							end
							default: begin
							end
						endcase
					end else if (pop && head.kind == KIND_TEST) begin
						edge_q  <= EDGE_W1;
						state_q <= ST_EMUL;
					end
				end
				ST_EMUL: begin
					state_q <= ST_ESUB;
				end
				ST_ESUB: begin
					if (edge_q == EDGE_AREA) begin
						k_q     <= '0;
						state_q <= ST_MMUL;
					end else begin
						edge_q  <= edge_q + 1'b1;
						state_q <= ST_EMUL;
					end
				end
				ST_MMUL: begin
					state_q <= ST_MADD;
				end
				ST_MADD: begin
					if (k_q == LAST_K) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_MMUL;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/triangle_pixel_raster_zbuffer.sv =====
// A pixel test passes through the queue to the back end, which evaluates
// edge functions, blends depth and color, divides by the area and hands
// off the result; the back end takes no new item before that handoff.
// Vertex loads and depth clears are done by the back end in its idle state.
// Reset clears control state, configuration and the triangle corners; the
// depth buffer holds no defined value until a clear writes it.
`timescale 1ns / 1ps

module triangle_pixel_raster_zbuffer #(
	parameter int SCREEN_WIDTH  = trpz_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = trpz_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  trpz_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output trpz_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import trpz_pkg::*;

	localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	cfg_t              cfg_q;
	logic              q_full;
	logic              push;
	cmd_t              push_data;
	logic              pop;
	logic              head_valid;
	cmd_t              head;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_clear <= DEPTH_CLEAR_RESET;
			cfg_q.max_x       <= MAX_PIXEL_RESET;
			cfg_q.max_y       <= MAX_PIXEL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEPTH_CLEAR: cfg_q.depth_clear <= cfg_data;
				REG_MAX_X:       cfg_q.max_x       <= cfg_data[8:0];
				REG_MAX_Y:       cfg_q.max_y       <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	trpz_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	trpz_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	trpz_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.cfg       (cfg_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	trpz_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_depth_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// ===== rtl/core/trpz_checker.sv =====
// Port-level checker of the triangle rasterizer and its bind to the top level.
// Depends on trpz_pkg and triangle_pixel_raster_zbuffer_defines.svh.
`timescale 1ns / 1ps
`include "triangle_pixel_raster_zbuffer_defines.svh"

module trpz_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input trpz_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input trpz_pkg::out_t out_data,
	input logic           cfg_valid,
	input logic           cfg_ready,
	input logic [1:0]     cfg_index,
	input logic [15:0]    cfg_data
);
	import trpz_pkg::*;

	logic [3:0] pend_q;
	logic [8:0] max_x_q;
	logic [8:0] max_y_q;
	logic       test_in;
	logic       res_out;

	assign test_in = in_valid && in_ready && (in_data.kind == KIND_TEST);
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			max_x_q <= MAX_PIXEL_RESET;
			max_y_q <= MAX_PIXEL_RESET;
		end else begin
			if (test_in && !res_out) begin
				pend_q <= pend_q + 1'b1;
			end else if (res_out && !test_in) begin
				pend_q <= pend_q - 1'b1;
			end
			if (cfg_valid && cfg_ready && cfg_index == REG_MAX_X) begin
				max_x_q <= cfg_data[8:0];
			end
			if (cfg_valid && cfg_ready && cfg_index == REG_MAX_Y) begin
				max_y_q <= cfg_data[8:0];
			end
		end
	end

	`TRPZ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`TRPZ_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed while stalled")
	`TRPZ_ASSERT(a_no_orphan, !out_valid || pend_q != 4'd0, "result without a pending pixel test")
	`TRPZ_ASSERT(a_write_in_limits, !(out_valid && out_data.pixel_written) || (out_data.out_x <= max_x_q && out_data.out_y <= max_y_q), "pixel written beyond limits")

endmodule

bind triangle_pixel_raster_zbuffer trpz_checker u_trpz_checker (.*);

// ===== tb/sv/tb_raster_checker.sv =====
// Scoreboard for the triangle rasterizer: watches the pixel, result and register channels,
// predicts each pixel test with its own depth buffer, and compares every result field.
// Depends on trpz_pkg for the payload types, operation codes and register indexes.
`timescale 1ns / 1ps

module tb_raster_checker
	import trpz_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_t        out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	logic [15:0] clear_depth;
	logic [8:0] limit_x, limit_y;
	logic signed [15:0] cx[3], cy[3];
	logic [15:0] cz[3];
	logic [7:0] cr[3], cg[3], cb[3];
	logic [15:0] zbuf[int];
	out_t fragments_due[$];

	function automatic longint edge_fn(int p, int q, longint px, longint py);
		longint x1, y1, x2, y2;
		x1 = longint'(cx[p]);
		y1 = longint'(cy[p]);
		x2 = longint'(cx[q]);
		y2 = longint'(cy[q]);
		return (px - x1) * (y2 - y1) - (py - y1) * (x2 - x1);
	endfunction

	function automatic logic [63:0] mix(logic [63:0] w1, logic [63:0] w2, logic [63:0] w3,
		logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] area);
		return (w1 * a + w2 * b + w3 * c) / area;
	endfunction

	function automatic logic [7:0] sat8(logic [63:0] v);
		return (v > 64'd255) ? COLOR_MAX : v[7:0];
	endfunction

	task automatic shade_pixel(input in_t d);
		out_t o;
		longint w1, w2, w3, area;
		logic [63:0] z;
		logic [15:0] stored;
		int idx;
		o = '0;
		o.out_x = d.pixel_x;
		o.out_y = d.pixel_y;
		idx = int'(d.pixel_y) * 512 + int'(d.pixel_x);
		w1 = edge_fn(1, 2, longint'(d.pixel_x) * 16, longint'(d.pixel_y) * 16);
		w2 = edge_fn(2, 0, longint'(d.pixel_x) * 16, longint'(d.pixel_y) * 16);
		w3 = edge_fn(0, 1, longint'(d.pixel_x) * 16, longint'(d.pixel_y) * 16);
		area = edge_fn(0, 1, longint'(cx[2]), longint'(cy[2]));
		if (d.pixel_x <= limit_x && d.pixel_y <= limit_y && area > 0
				&& w1 >= 0 && w2 >= 0 && w3 >= 0) begin
			z = mix(w1, w2, w3, 64'(cz[0]), 64'(cz[1]), 64'(cz[2]), area);
			if (z > 64'hFFFF)
				z = 64'hFFFF;
			o.out_depth = z[15:0];
			o.out_red = sat8(mix(w1, w2, w3, 64'(cr[0]), 64'(cr[1]), 64'(cr[2]), area));
			o.out_green = sat8(mix(w1, w2, w3, 64'(cg[0]), 64'(cg[1]), 64'(cg[2]), area));
			o.out_blue = sat8(mix(w1, w2, w3, 64'(cb[0]), 64'(cb[1]), 64'(cb[2]), area));
			stored = zbuf.exists(idx) ? zbuf[idx] : 16'd0;
			if (z[15:0] < stored) begin
				zbuf[idx] = z[15:0];
				o.pixel_written = 1'b1;
			end
		end
		fragments_due.push_back(o);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		int slot;
		if (!arst_n) begin
			clear_depth = DEPTH_CLEAR_RESET;
			limit_x = MAX_PIXEL_RESET;
			limit_y = MAX_PIXEL_RESET;
			for (int k = 0; k < 3; k++) begin
				cx[k] = '0;
				cy[k] = '0;
				cz[k] = '0;
				cr[k] = '0;
				cg[k] = '0;
				cb[k] = '0;
			end
			zbuf.delete();
			fragments_due.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (fragments_due.size() == 0) begin
					report_mismatch("unexpected transaction, pixel x",
						longint'(out_data.out_x), -1);
				end else begin
					want = fragments_due.pop_front();
					if (out_data.out_x !== want.out_x)
						report_mismatch("out_x", longint'(out_data.out_x),
							longint'(want.out_x));
					if (out_data.out_y !== want.out_y)
						report_mismatch("out_y", longint'(out_data.out_y),
							longint'(want.out_y));
					if (out_data.pixel_written !== want.pixel_written)
						report_mismatch("pixel_written", longint'(out_data.pixel_written),
							longint'(want.pixel_written));
					if (out_data.out_red !== want.out_red)
						report_mismatch("out_red", longint'(out_data.out_red),
							longint'(want.out_red));
					if (out_data.out_green !== want.out_green)
						report_mismatch("out_green", longint'(out_data.out_green),
							longint'(want.out_green));
					if (out_data.out_blue !== want.out_blue)
						report_mismatch("out_blue", longint'(out_data.out_blue),
							longint'(want.out_blue));
					if (out_data.out_depth !== want.out_depth)
						report_mismatch("out_depth", longint'(out_data.out_depth),
							longint'(want.out_depth));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEPTH_CLEAR: clear_depth = cfg_data;
					REG_MAX_X: limit_x = cfg_data[8:0];
					REG_MAX_Y: limit_y = cfg_data[8:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				slot = int'(in_data.vertex_slot);
				if (in_data.kind == KIND_LOAD && slot < 3) begin
					cx[slot] = in_data.vertex_x;
					cy[slot] = in_data.vertex_y;
					cz[slot] = in_data.vertex_depth;
					cr[slot] = in_data.vertex_red;
					cg[slot] = in_data.vertex_green;
					cb[slot] = in_data.vertex_blue;
				end else if (in_data.kind == KIND_CLEAR) begin
					zbuf[int'(in_data.pixel_y) * 512 + int'(in_data.pixel_x)] = clear_depth;
				end else if (in_data.kind == KIND_TEST) begin
					shade_pixel(in_data);
				end
			end
			pending <= fragments_due.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the rasterizer testbench: clock, reset, bursty pixel stimulus, register phases
// and a stalling result receiver. Depends on trpz_pkg, the block and tb_raster_checker.
`timescale 1ns / 1ps

module tb_top;
	import trpz_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] SLOT_NONE = 2'd3;
	localparam int PHASE_ITEMS = 320;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_t in_data;
	out_t out_data;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	int fail_count, pending;
	int items_sent = 0;
	int burst_left = 0;
	int ready_mode = 0, mode_left = 0;
	logic hold_off = 1'b0;
	int cleared_list[$];
	int episode_list[$];

	always #10 clk = ~clk;

	triangle_pixel_raster_zbuffer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tb_raster_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 200);
			end
			mode_left--;
			if (hold_off)
				out_ready <= 1'b0;
			else if (ready_mode == 0)
				out_ready <= 1'b1;
			else if (ready_mode == 1)
				out_ready <= ($urandom_range(0, 1) == 0);
			else if (ready_mode == 2)
				out_ready <= ($urandom_range(0, 7) == 0);
			else
				out_ready <= ($urandom_range(0, 7) != 0);
		end
	end

	initial begin
		wait (items_sent >= 150);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (600) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#50ms;
		$display("triangle_pixel_raster_zbuffer: mismatch");
		$finish;
	end

	task automatic send(input in_t d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= d;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	function automatic in_t noise_item();
		logic [95:0] raw;
		in_t d;
		raw = {$urandom, $urandom, $urandom};
		d = raw[$bits(in_t)-1:0];
		return d;
	endfunction

	task automatic clear_px(input int x, input int y);
		in_t d;
		d = noise_item();
		d.kind = KIND_CLEAR;
		d.pixel_x = 9'(x);
		d.pixel_y = 9'(y);
		send(d);
		cleared_list.push_back(x * 512 + y);
		episode_list.push_back(x * 512 + y);
	endtask

	task automatic load_corner(input logic [1:0] slot, input int x, input int y,
		input int z, input int r, input int g, input int b);
		in_t d;
		d = noise_item();
		d.kind = KIND_LOAD;
		d.vertex_slot = slot;
		d.vertex_x = 16'(x);
		d.vertex_y = 16'(y);
		d.vertex_depth = 16'(z);
		d.vertex_red = 8'(r);
		d.vertex_green = 8'(g);
		d.vertex_blue = 8'(b);
		send(d);
	endtask

	task automatic test_px(input int x, input int y);
		in_t d;
		d = noise_item();
		d.kind = KIND_TEST;
		d.pixel_x = 9'(x);
		d.pixel_y = 9'(y);
		send(d);
	endtask

	task automatic settle();
		int n;
		n = 0;
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0 && n < 40000) begin
			@(posedge clk);
			n++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_regs(input int depth, input int mx, input int my);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_DEPTH_CLEAR;
		cfg_data <= 16'(depth);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MAX_X;
		cfg_data <= 16'(mx);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MAX_Y;
		cfg_data <= 16'(my);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic episode();
		int bx, by, base_x, base_y, k, pick;
		in_t d;
		bx = $urandom_range(0, 508);
		by = $urandom_range(0, 508);
		episode_list.delete();
		repeat ($urandom_range(2, 5))
			clear_px(bx + $urandom_range(0, 3), by + $urandom_range(0, 3));
		base_x = bx * 16;
		base_y = by * 16;
		for (k = 0; k < 3; k++) begin
			if ($urandom_range(0, 9) == 0)
				load_corner(2'(k), $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
			else
				load_corner(2'(k), base_x + $urandom_range(0, 160) - 48,
					base_y + $urandom_range(0, 160) - 48, $urandom_range(0, 65535),
					$urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
		end
		repeat ($urandom_range(3, 9)) begin
			if ($urandom_range(0, 4) == 0)
				pick = cleared_list[$urandom_range(0, cleared_list.size() - 1)];
			else
				pick = episode_list[$urandom_range(0, episode_list.size() - 1)];
			test_px(pick / 512, pick % 512);
		end
		if ($urandom_range(0, 5) == 0) begin
			d = noise_item();
			if ($urandom_range(0, 1) == 0) begin
				d.kind = KIND_UNUSED;
			end else begin
				d.kind = KIND_LOAD;
				d.vertex_slot = SLOT_NONE;
			end
			send(d);
		end
	endtask

	initial begin
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DEPTH_CLEAR;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		clear_px(0, 0);
		clear_px(511, 511);
		clear_px(0, 511);
		clear_px(511, 0);
		clear_px(255, 256);
		load_corner(2'd0, -32768, -32768, 0, 255, 0, 255);
		load_corner(2'd1, -32768, 32767, 65535, 0, 255, 0);
		load_corner(2'd2, 32767, 32767, 30000, 255, 255, 0);
		test_px(0, 0);
		test_px(0, 511);
		test_px(511, 0);
		test_px(255, 256);
		test_px(0, 0);
		test_px(511, 511);
		load_corner(SLOT_NONE, 100, 100, 5, 1, 2, 3);
		send('{kind: KIND_UNUSED, pixel_x: 9'd7, pixel_y: 9'd7, default: '0});
		load_corner(2'd2, -32768, -32768, 10, 10, 10, 10);
		test_px(0, 0);
		load_corner(2'd1, 32767, 32767, 65535, 0, 255, 0);
		load_corner(2'd2, -32768, 32767, 30000, 255, 255, 0);
		test_px(0, 511);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: write_regs(65535, 511, 511);
				2: write_regs(0, 0, 511);
				3: write_regs($urandom_range(0, 65535), 511, 0);
				4: write_regs($urandom_range(0, 65535), $urandom_range(0, 511),
					$urandom_range(0, 511));
				5: write_regs(25600, 511, 511);
				default: ;
			endcase
			while (items_sent < (phase + 1) * PHASE_ITEMS)
				episode();
		end

		settle();
		if (pending == 0 && fail_count == 0)
			$display("triangle_pixel_raster_zbuffer: match");
		else
			$display("triangle_pixel_raster_zbuffer: mismatch");
		$finish;
	end

endmodule
